// ===== rtl/core/pcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_pkg: shared types and constants
// Register map, configuration struct, back-end states and fixed widths.
// ----------------------------------------------------------------------------
package pcr_pkg;

  // table geometry; all sizes are powers of two so index reduction is a mask
  localparam int unsigned NUM_SETS         = 2048;
  localparam int unsigned NUM_WAYS         = 16;
  localparam int unsigned PC_TABLE_ENTRIES = 4096;
  localparam int unsigned SAW              = $clog2(NUM_SETS);
  localparam int unsigned WAW              = $clog2(NUM_WAYS);
  localparam int unsigned PC_AW            = $clog2(PC_TABLE_ENTRIES);

  localparam int unsigned LINE_OFFSET_BITS = 6;
  localparam int unsigned AGE_CAP          = 65535;
  localparam int unsigned AGE_W            = 16;
  localparam int unsigned COUNT_W          = 32;
  localparam int unsigned PROD_W           = 39;
  localparam int unsigned SCORE_W          = 18;
  localparam logic [6:0]  PCT_SCALE        = 7'd100;

  localparam logic FUNC_VICTIM = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam logic [15:0] ACC_WINDOW_RST = 16'd128;
  localparam logic [6:0]  STREAM_PCT_RST = 7'd85;
  localparam logic [7:0]  NEAR_SPAN_RST  = 8'd4;
  localparam logic [2:0]  REUSE_MAX_RST  = 3'd7;

  typedef enum logic [1:0] {
    REG_ACC_WINDOW = 2'd0,
    REG_STREAM_PCT = 2'd1,
    REG_NEAR_SPAN  = 2'd2,
    REG_REUSE_MAX  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] acc_window;
    logic [6:0]  stream_pct;
    logic [7:0]  near_span;
    logic [2:0]  reuse_max;
  } cfg_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_CNT_RD,
    B_CNT_WR,
    B_PHASE,
    B_LINE_RD,
    B_PC_RD,
    B_SCORE,
    B_RESULT,
    B_UPD_RD,
    B_UPD_WR
  } back_state_e;

endpackage

// ===== rtl/core/pcr_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_mod: remainder by a power-of-two constant
// Registers the low bits of the operand; DIV is always a power of two.
// ----------------------------------------------------------------------------
module pcr_mod #(
  parameter int unsigned DIV  = 2,
  parameter int unsigned IN_W = 8,
  localparam int unsigned OUT_W = (DIV > 1) ? $clog2(DIV) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  x_i,
  output logic             busy_o,
  output logic [OUT_W-1:0] rem_o
);

  logic [OUT_W-1:0] rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (start_i) begin
      rem_q <= OUT_W'(x_i) & OUT_W'(DIV - 1);
    end
  end

  assign busy_o = 1'b0;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/pcr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_fifo: small decoupling queue
// Register-based first-in first-out store between front and back end.
// ----------------------------------------------------------------------------
module pcr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/pcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_front: request intake and classification
// Takes one transaction, reduces set, way and hashed PC, and queues it.
// ----------------------------------------------------------------------------
module pcr_front #(
  parameter int unsigned TAG_BITS = 42,
  localparam int unsigned QW = 2 + pcr_pkg::SAW + pcr_pkg::WAW + TAG_BITS + pcr_pkg::PC_AW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          hold_i,
  input  logic          push_i,
  output logic          full_o,
  input  logic          func_i,
  input  logic [10:0]   set_index_i,
  input  logic [3:0]    way_index_i,
  input  logic [47:0]   phys_addr_i,
  input  logic [47:0]   prog_counter_i,
  input  logic          was_hit_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output logic [QW-1:0] q_data_o
);

  import pcr_pkg::*;

  logic                busy_q;
  logic                func_q, hit_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                accept;
  logic [47:0]         pc_hash;
  logic                set_busy, way_busy, slot_busy;
  logic [SAW-1:0]      set_rem;
  logic [WAW-1:0]      way_rem;
  logic [PC_AW-1:0]    slot_rem;
  logic                ready;

  assign full_o  = busy_q || hold_i;
  assign accept  = push_i && !full_o;
  assign pc_hash = prog_counter_i ^ (prog_counter_i >> 12) ^ (prog_counter_i >> 24)
                 ^ (prog_counter_i >> 36);

  pcr_mod #(.DIV(NUM_SETS), .IN_W(11)) u_set_mod (
    .clk_i, .rst_ni, .start_i(accept), .x_i(set_index_i),
    .busy_o(set_busy), .rem_o(set_rem)
  );

  pcr_mod #(.DIV(NUM_WAYS), .IN_W(4)) u_way_mod (
    .clk_i, .rst_ni, .start_i(accept), .x_i(way_index_i),
    .busy_o(way_busy), .rem_o(way_rem)
  );

  pcr_mod #(.DIV(PC_TABLE_ENTRIES), .IN_W(48)) u_slot_mod (
    .clk_i, .rst_ni, .start_i(accept), .x_i(pc_hash),
    .busy_o(slot_busy), .rem_o(slot_rem)
  );

  assign ready    = busy_q && !set_busy && !way_busy && !slot_busy;
  assign q_push_o = ready && !q_full_i;
  assign q_data_o = {func_q, set_rem, way_rem, tag_q, slot_rem, hit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (q_push_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      hit_q  <= was_hit_i;
      tag_q  <= TAG_BITS'(phys_addr_i[47:LINE_OFFSET_BITS]);
    end
  end

endmodule

// ===== rtl/core/pcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_back: replacement state and victim scoring
// Owns the line, set-count and PC-counter memories; scores one way at a time.
// ----------------------------------------------------------------------------
module pcr_back #(
  parameter int unsigned STAMP_BITS = 32,
  parameter int unsigned TAG_BITS   = 42,
  localparam int unsigned QW = 2 + pcr_pkg::SAW + pcr_pkg::WAW + TAG_BITS + pcr_pkg::PC_AW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcr_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  input  logic [QW-1:0]  q_data_i,
  output logic           q_pop_o,
  input  logic           res_pop_i,
  output logic           res_empty_o,
  output logic [3:0]     victim_way_o,
  output logic           streaming_flag_o,
  output logic           clearing_o
);

  import pcr_pkg::*;

  localparam int unsigned LAW   = SAW + WAW;
  localparam int unsigned LW    = TAG_BITS + PC_AW + STAMP_BITS;
  localparam int unsigned CLR_W = (LAW > PC_AW) ? LAW : PC_AW;
  localparam logic signed [SCORE_W-1:0] S_ZERO = '0;

  back_state_e state_q, state_d;

  // queue entry fields
  logic                e_func, e_hit;
  logic [SAW-1:0]      e_set;
  logic [WAW-1:0]      e_way;
  logic [TAG_BITS-1:0] e_tag;
  logic [PC_AW-1:0]    e_slot;

  logic                hit_q;
  logic [SAW-1:0]      set_q;
  logic [WAW-1:0]      way_in_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [PC_AW-1:0]    slot_q;

  logic [CLR_W-1:0]    clr_cnt_q;
  logic [WAW-1:0]      way_q;
  logic [COUNT_W-1:0]  acc_q;
  logic [PROD_W-1:0]   prod_m_q, prod_a_q;
  logic                streaming_q;
  logic [AGE_W-1:0]    age_q;
  logic                near_q;
  logic signed [SCORE_W-1:0] best_q;
  logic [WAW-1:0]      victim_q;
  logic                res_valid_q, res_stream_q;
  logic [3:0]          res_way_q;

  // memories
  logic [LW-1:0]        line_mem [2**LAW];
  logic [2*COUNT_W-1:0] set_mem  [2**SAW];
  logic [2:0]           pc_mem   [2**PC_AW];
  logic [LW-1:0]        line_rdata_q;
  logic [2*COUNT_W-1:0] set_rdata_q;
  logic [2:0]           pc_rdata_q;

  logic                 line_we, set_we, pc_we;
  logic [LAW-1:0]       line_waddr;
  logic [LW-1:0]        line_wdata;
  logic [SAW-1:0]       set_waddr;
  logic [2*COUNT_W-1:0] set_wdata;
  logic [PC_AW-1:0]     pc_waddr, pc_raddr;
  logic [2:0]           pc_wdata;

  // datapath
  logic [COUNT_W-1:0]    rd_acc, rd_miss, acc_inc, miss_inc;
  logic [TAG_BITS-1:0]   l_tag, tag_gap;
  logic [PC_AW-1:0]      l_slot;
  logic [STAMP_BITS-1:0] l_stamp, age_full;
  logic [63:0]           age_wide;
  logic [AGE_W-1:0]      age_sat;
  logic                  near;
  logic signed [SCORE_W-1:0] s_age, s_reuse, s_rmax, s_diff, score;
  logic [2:0]            ctr_next;
  logic                  last_way, can_load;

  assign {e_func, e_set, e_way, e_tag, e_slot, e_hit} = q_data_i;

  assign q_pop_o          = (state_q == B_IDLE) && !q_empty_i;
  assign clearing_o       = state_q == B_CLEAR;
  assign res_empty_o      = !res_valid_q;
  assign victim_way_o     = res_way_q;
  assign streaming_flag_o = res_stream_q;
  assign last_way         = way_q == WAW'(NUM_WAYS - 1);
  assign can_load         = !res_valid_q || res_pop_i;

  // ---- scoring datapath ----
  always_comb begin
    rd_acc   = set_rdata_q[2*COUNT_W-1:COUNT_W];
    rd_miss  = set_rdata_q[COUNT_W-1:0];
    acc_inc  = (rd_acc == '1) ? rd_acc : rd_acc + 1'b1;
    miss_inc = (rd_miss == '1) ? rd_miss : rd_miss + 1'b1;

    l_tag    = line_rdata_q[LW-1 -: TAG_BITS];
    l_slot   = line_rdata_q[STAMP_BITS +: PC_AW];
    l_stamp  = line_rdata_q[STAMP_BITS-1:0];
    age_full = STAMP_BITS'(acc_q) - l_stamp;
    age_wide = 64'(age_full);
    age_sat  = (age_wide > 64'(AGE_CAP)) ? AGE_W'(AGE_CAP) : age_wide[AGE_W-1:0];
    tag_gap  = (l_tag >= tag_q) ? (l_tag - tag_q) : (tag_q - l_tag);
    near     = tag_gap <= TAG_BITS'(cfg_i.near_span);

    s_age   = SCORE_W'(age_q);
    s_reuse = SCORE_W'(pc_rdata_q);
    s_rmax  = SCORE_W'(cfg_i.reuse_max);
    s_diff  = s_rmax - s_reuse;
    if (streaming_q) begin
      score = s_age - (s_reuse <<< 1) - (near_q ? SCORE_W'(2) : S_ZERO);
    end else begin
      score = s_age + (s_diff <<< 1) + s_diff + (near_q ? S_ZERO : SCORE_W'(2));
    end

    if (hit_q) begin
      ctr_next = (pc_rdata_q < cfg_i.reuse_max) ? pc_rdata_q + 1'b1 : pc_rdata_q;
    end else begin
      ctr_next = (pc_rdata_q != '0) ? pc_rdata_q - 1'b1 : pc_rdata_q;
    end
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR:   if (clr_cnt_q == '1) state_d = B_IDLE;
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = (e_func == FUNC_UPDATE) ? B_UPD_RD : B_CNT_RD;
        end
      end
      B_CNT_RD:  state_d = B_CNT_WR;
      B_CNT_WR:  state_d = B_PHASE;
      B_PHASE:   state_d = B_LINE_RD;
      B_LINE_RD: state_d = B_PC_RD;
      B_PC_RD:   state_d = B_SCORE;
      B_SCORE:   state_d = last_way ? B_RESULT : B_LINE_RD;
      B_RESULT:  if (can_load) state_d = B_IDLE;
      B_UPD_RD:  state_d = B_UPD_WR;
      B_UPD_WR:  state_d = B_IDLE;
      default:   state_d = B_CLEAR;
    endcase
  end

  // ---- memory controls ----
  always_comb begin
    line_we    = 1'b0;
    set_we     = 1'b0;
    pc_we      = 1'b0;
    line_waddr = {set_q, way_in_q};
    line_wdata = {tag_q, slot_q, STAMP_BITS'(rd_acc)};
    set_waddr  = set_q;
    set_wdata  = {acc_inc, rd_miss};
    pc_waddr   = slot_q;
    pc_wdata   = ctr_next;
    pc_raddr   = (state_q == B_PC_RD) ? l_slot : slot_q;
    unique case (state_q)
      B_CLEAR: begin
        line_we    = 1'b1;
        set_we     = 1'b1;
        pc_we      = 1'b1;
        line_waddr = clr_cnt_q[LAW-1:0];
        line_wdata = '0;
        set_waddr  = clr_cnt_q[SAW-1:0];
        set_wdata  = '0;
        pc_waddr   = clr_cnt_q[PC_AW-1:0];
        pc_wdata   = '0;
      end
      B_CNT_WR: set_we = 1'b1;
      B_UPD_WR: begin
        line_we   = 1'b1;
        set_we    = 1'b1;
        pc_we     = 1'b1;
        set_wdata = {rd_acc, hit_q ? rd_miss : miss_inc};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    line_rdata_q <= line_mem[{set_q, way_q}];
  end

  always_ff @(posedge clk_i) begin
    if (set_we) begin
      set_mem[set_waddr] <= set_wdata;
    end
    set_rdata_q <= set_mem[set_q];
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) begin
      pc_mem[pc_waddr] <= pc_wdata;
    end
    pc_rdata_q <= pc_mem[pc_raddr];
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == B_RESULT && can_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      hit_q    <= e_hit;
      set_q    <= e_set;
      way_in_q <= e_way;
      tag_q    <= e_tag;
      slot_q   <= e_slot;
    end
    if (state_q == B_CNT_WR) begin
      acc_q    <= acc_inc;
      prod_m_q <= PROD_W'(rd_miss) * PROD_W'(PCT_SCALE);
      prod_a_q <= PROD_W'(acc_inc) * PROD_W'(cfg_i.stream_pct);
    end
    if (state_q == B_PHASE) begin
      streaming_q <= (acc_q > COUNT_W'(cfg_i.acc_window)) && (prod_m_q > prod_a_q);
      way_q       <= '0;
    end
    if (state_q == B_PC_RD) begin
      age_q  <= age_sat;
      near_q <= near;
    end
    if (state_q == B_SCORE) begin
      if (way_q == '0 || score < best_q) begin
        best_q   <= score;
        victim_q <= way_q;
      end
      way_q <= way_q + 1'b1;
    end
    if (state_q == B_RESULT && can_load) begin
      res_way_q    <= 4'(victim_q);
      res_stream_q <= streaming_q;
    end
  end

endmodule

// ===== rtl/core/pc_reuse_phase_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_reuse_phase_replacement_core: PC-reuse, phase-aware LLC replacement
// Victim selection from age, per-PC reuse and tag nearness, with a per-set
// streaming detector; updates record tag, PC slot and access stamp.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  request  | push / full           | func, set_index, way_index, phys_addr,
//           |                       | prog_counter, was_hit
//  result   | pop / empty           | victim_way, streaming_flag
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// Steps: the front end handles one transaction at a time (register the
// masked set, way and PC slot, then hand it to the queue, waiting while it
// is full). A victim request in the back end runs pop, count read, count
// write, phase test, then one line read, one PC-counter read and one score
// per way, then the result load; an update runs pop, read and write.
// Reset: the back end sweeps all memories; full stays high meanwhile.
// Stalls: a two-entry queue decouples front and back; one result register
// holds a victim until popped while the back end keeps working, stalling
// only at its next result load until that pop.
module pc_reuse_phase_replacement_core #(
  parameter int unsigned STAMP_BITS = 32,
  parameter int unsigned TAG_BITS   = 42
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request queue
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_index_i,
  input  logic [47:0] phys_addr_i,
  input  logic [47:0] prog_counter_i,
  input  logic        was_hit_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  victim_way_o,
  output logic        streaming_flag_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import pcr_pkg::*;

  localparam int unsigned QW          = 2 + SAW + WAW + TAG_BITS + PC_AW;
  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t          cfg_q;
  cfg_reg_e      reg_sel;
  logic          cfg_wr;
  logic          clearing;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          res_pop;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acc_window <= ACC_WINDOW_RST;
      cfg_q.stream_pct <= STREAM_PCT_RST;
      cfg_q.near_span  <= NEAR_SPAN_RST;
      cfg_q.reuse_max  <= REUSE_MAX_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ACC_WINDOW: cfg_q.acc_window <= pwdata[15:0];
        REG_STREAM_PCT: cfg_q.stream_pct <= pwdata[6:0];
        REG_NEAR_SPAN:  cfg_q.near_span  <= pwdata[7:0];
        REG_REUSE_MAX:  cfg_q.reuse_max  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // read back the addressed register, zero-extended
  always_comb begin
    unique case (reg_sel)
      REG_ACC_WINDOW: prdata = 32'(cfg_q.acc_window);
      REG_STREAM_PCT: prdata = 32'(cfg_q.stream_pct);
      REG_NEAR_SPAN:  prdata = 32'(cfg_q.near_span);
      REG_REUSE_MAX:  prdata = 32'(cfg_q.reuse_max);
      default:        prdata = '0;
    endcase
  end

  // ---- front end: accept, reduce indices, hash PC ----
  pcr_front #(
    .TAG_BITS(TAG_BITS)
  ) u_front (
    .clk_i, .rst_ni,
    .hold_i(clearing),
    .push_i(push),
    .full_o(full),
    .func_i, .set_index_i, .way_index_i, .phys_addr_i, .prog_counter_i, .was_hit_i,
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  // ---- decoupling queue ----
  pcr_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_rdata), .empty_o(q_empty)
  );

  // ---- back end: counts, scoring, state updates ----
  assign res_pop = pop && !empty;

  pcr_back #(
    .STAMP_BITS(STAMP_BITS), .TAG_BITS(TAG_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q),
    .q_empty_i(q_empty),
    .q_data_i(q_rdata),
    .q_pop_o(q_pop),
    .res_pop_i(res_pop),
    .res_empty_o(empty),
    .victim_way_o,
    .streaming_flag_o,
    .clearing_o(clearing)
  );

  // ---- checks ----
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full)
    else $error("request accepted while memories are being cleared");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> empty)
    else $error("result pending during memory clear");

  a_victim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (NUM_WAYS >= 16 || 32'(victim_way_o) < NUM_WAYS))
    else $error("victim way beyond way count");

endmodule
